>>> hw/rtl/assert_macros.svh
// Assertion macros for the xor_split_max_sum RTL.
// Clocked on clock; XSM_ASSERT is disabled while reset is high, XSM_ASSERT_NORST is not.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define XSM_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

`define XSM_ASSERT_NORST(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

>>> hw/rtl/xsm_pkg.sv
// Package for xor_split_max_sum: cell operations, cell control and sequencer states.
// No dependencies.
`timescale 1ns / 1ps

package xsm_pkg;

   typedef enum logic [2:0] {
      OP_IDLE   = 3'd0,
      OP_ABSORB = 3'd1,
      OP_GREEDY = 3'd2,
      OP_SHIFT  = 3'd3,
      OP_CLEAR  = 3'd4
   } cell_op_type;

   typedef struct packed {
      cell_op_type op;
   } cell_ctrl_type;

   typedef enum logic [5:0] {
      ST_ABSORB = 6'b000001,
      ST_DRAIN  = 6'b000010,
      ST_UNLOAD = 6'b000100,
      ST_SETTLE = 6'b001000,
      ST_GREEDY = 6'b010000,
      ST_OUT    = 6'b100000
   } state_type;

endpackage

>>> hw/rtl/xor_split_max_sum_top.sv
// xor_split_max_sum top level: two chains of basis cells and the set sequencer.
// Depends on xsm_pkg, xsm_cell and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Values stream in one per cycle through chain A while the block is absorbing, a row
// of VALUE_BITS cells that each keep the basis row of one leading bit. After the
// transfer marked last the block stops taking input: it drains chain A, shifts its
// rows, masked by the complement of the running XOR, into chain B, lets chain B
// settle, walks a greedy token through chain B and catches it, and holds the result
// 2*M+T in an output register; the next set starts once it is taken.
module xor_split_max_sum_top #(
   parameter int VALUE_BITS = 60
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [VALUE_BITS-1:0] req_value,
   input  logic                  req_last,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [VALUE_BITS:0]   rsp_max_sum
);

   localparam int CW = (VALUE_BITS > 1) ? $clog2(VALUE_BITS) : 1;

   xsm_pkg::state_type    state_ff, state_in;
   logic [CW-1:0]         count_ff, count_in;
   logic [VALUE_BITS-1:0] total_xor_ff, total_xor_in;
   logic [VALUE_BITS:0]   rsp_max_sum_ff, rsp_max_sum_in;
   logic                  accept, count_end;
   xsm_pkg::cell_ctrl_type a_ctrl, b_ctrl;

   logic [VALUE_BITS-1:0] a_vec  [VALUE_BITS+1];
   logic                  a_vld  [VALUE_BITS+1];
   logic [VALUE_BITS-1:0] a_row  [VALUE_BITS+1];
   logic                  a_rowv [VALUE_BITS+1];
   logic [VALUE_BITS-1:0] b_vec  [VALUE_BITS+1];
   logic                  b_vld  [VALUE_BITS+1];
   logic [VALUE_BITS-1:0] b_row  [VALUE_BITS+1];
   logic                  b_rowv [VALUE_BITS+1];
   logic [VALUE_BITS-1:0] a_rowv_vec;

   assign req_ready = (state_ff == xsm_pkg::ST_ABSORB);
   assign accept    = req_valid && req_ready;
   assign count_end = (count_ff == CW'(VALUE_BITS - 1));
   assign rsp_valid = (state_ff == xsm_pkg::ST_OUT);
   assign rsp_max_sum = rsp_max_sum_ff;

   assign a_vec[0]  = req_value;
   assign a_vld[0]  = accept;
   assign a_row[0]  = '0;
   assign a_rowv[0] = 1'b0;
   assign b_vec[0]  = (state_ff == xsm_pkg::ST_UNLOAD) ? (a_row[VALUE_BITS] & ~total_xor_ff)
                                                       : '0;
   assign b_vld[0]  = (state_ff == xsm_pkg::ST_UNLOAD) ? a_rowv[VALUE_BITS]
                    : ((state_ff == xsm_pkg::ST_GREEDY) && (count_ff == '0));
   assign b_row[0]  = '0;
   assign b_rowv[0] = 1'b0;

   always_comb begin
      a_ctrl.op = xsm_pkg::OP_IDLE;
      b_ctrl.op = xsm_pkg::OP_IDLE;
      unique case (state_ff) inside
         xsm_pkg::ST_ABSORB, xsm_pkg::ST_DRAIN: a_ctrl.op = xsm_pkg::OP_ABSORB;
         xsm_pkg::ST_UNLOAD: begin
            a_ctrl.op = xsm_pkg::OP_SHIFT;
            b_ctrl.op = xsm_pkg::OP_ABSORB;
         end
         xsm_pkg::ST_SETTLE: b_ctrl.op = xsm_pkg::OP_ABSORB;
         xsm_pkg::ST_GREEDY: b_ctrl.op = xsm_pkg::OP_GREEDY;
         xsm_pkg::ST_OUT:    b_ctrl.op = xsm_pkg::OP_CLEAR;
         default: ;
      endcase
   end

   genvar gi;
   generate
      for (gi = 0; gi < VALUE_BITS; gi++) begin : g_cells
         xsm_cell #(.VALUE_BITS(VALUE_BITS), .PIVOT(VALUE_BITS - 1 - gi)) u_a (
            .clock (clock), .reset (reset), .ctrl (a_ctrl),
            .vec_i (a_vec[gi]),   .vld_i (a_vld[gi]),
            .row_i (a_row[gi]),   .rowv_i (a_rowv[gi]),
            .vec_o (a_vec[gi+1]), .vld_o (a_vld[gi+1]),
            .row_o (a_row[gi+1]), .rowv_o (a_rowv[gi+1])
         );
         xsm_cell #(.VALUE_BITS(VALUE_BITS), .PIVOT(VALUE_BITS - 1 - gi)) u_b (
            .clock (clock), .reset (reset), .ctrl (b_ctrl),
            .vec_i (b_vec[gi]),   .vld_i (b_vld[gi]),
            .row_i (b_row[gi]),   .rowv_i (b_rowv[gi]),
            .vec_o (b_vec[gi+1]), .vld_o (b_vld[gi+1]),
            .row_o (b_row[gi+1]), .rowv_o (b_rowv[gi+1])
         );
         assign a_rowv_vec[gi] = a_rowv[gi+1];
      end
   endgenerate

   always_comb begin
      state_in       = state_ff;
      count_in       = count_ff;
      total_xor_in   = total_xor_ff;
      rsp_max_sum_in = rsp_max_sum_ff;
      unique case (state_ff)
         xsm_pkg::ST_ABSORB: begin
            if (accept) begin
               total_xor_in = total_xor_ff ^ req_value;
               if (req_last) begin
                  state_in = xsm_pkg::ST_DRAIN;
                  count_in = '0;
               end
            end
         end
         xsm_pkg::ST_DRAIN: begin
            count_in = count_end ? '0 : count_ff + 1'b1;
            if (count_end) state_in = xsm_pkg::ST_UNLOAD;
         end
         xsm_pkg::ST_UNLOAD: begin
            count_in = count_end ? '0 : count_ff + 1'b1;
            if (count_end) state_in = xsm_pkg::ST_SETTLE;
         end
         xsm_pkg::ST_SETTLE: begin
            count_in = count_end ? '0 : count_ff + 1'b1;
            if (count_end) state_in = xsm_pkg::ST_GREEDY;
         end
         xsm_pkg::ST_GREEDY: begin
            count_in = count_end ? '0 : count_ff + 1'b1;
            if (b_vld[VALUE_BITS]) begin
               rsp_max_sum_in = {b_vec[VALUE_BITS], 1'b0} + {1'b0, total_xor_ff};
               state_in       = xsm_pkg::ST_OUT;
            end
         end
         xsm_pkg::ST_OUT: begin
            if (rsp_ready) begin
               total_xor_in = '0;
               state_in     = xsm_pkg::ST_ABSORB;
            end
         end
         default: state_in = xsm_pkg::ST_ABSORB;
      endcase
   end

   always_ff @(posedge clock) begin
      rsp_max_sum_ff <= rsp_max_sum_in;
      if (reset) begin
         state_ff     <= xsm_pkg::ST_ABSORB;
         count_ff     <= '0;
         total_xor_ff <= '0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         total_xor_ff <= total_xor_in;
      end
   end

   `XSM_ASSERT(a_no_ready_with_rsp, rsp_valid |-> !req_ready, "input open while result pending")
   `XSM_ASSERT(a_xor_cleared, (rsp_valid && rsp_ready) |=> (total_xor_ff == '0), "total xor kept")
   `XSM_ASSERT(a_chain_a_empty, (state_ff == xsm_pkg::ST_SETTLE) |-> (a_rowv_vec == '0), "chain A not emptied")

endmodule

>>> hw/rtl/xsm_cell.sv
// One basis cell: holds the row whose leading bit is PIVOT and passes a vector on.
// Depends on xsm_pkg.
`timescale 1ns / 1ps

module xsm_cell #(
   parameter int VALUE_BITS = 60,
   parameter int PIVOT      = 0
) (
   input  logic                     clock,
   input  logic                     reset,
   input  xsm_pkg::cell_ctrl_type   ctrl,
   input  logic [VALUE_BITS-1:0]    vec_i,
   input  logic                     vld_i,
   input  logic [VALUE_BITS-1:0]    row_i,
   input  logic                     rowv_i,
   output logic [VALUE_BITS-1:0]    vec_o,
   output logic                     vld_o,
   output logic [VALUE_BITS-1:0]    row_o,
   output logic                     rowv_o
);

   logic [VALUE_BITS-1:0] row_ff, row_in, vec_ff, vec_in;
   logic                  rowv_ff, rowv_in, vld_ff, vld_in;

   always_comb begin
      row_in  = row_ff;
      rowv_in = rowv_ff;
      vec_in  = vec_i;
      vld_in  = vld_i;
      unique case (ctrl.op)
         xsm_pkg::OP_IDLE: begin
            vld_in = 1'b0;
         end
         xsm_pkg::OP_ABSORB: begin
            if (vld_i && vec_i[PIVOT]) begin
               if (!rowv_ff) begin
                  row_in  = vec_i;
                  rowv_in = 1'b1;
                  vec_in  = '0;
               end else begin
                  vec_in = vec_i ^ row_ff;
               end
            end
         end
         xsm_pkg::OP_GREEDY: begin
            if (vld_i && rowv_ff && !vec_i[PIVOT]) begin
               vec_in = vec_i ^ row_ff;
            end
         end
         xsm_pkg::OP_SHIFT: begin
            row_in  = row_i;
            rowv_in = rowv_i;
            vld_in  = 1'b0;
         end
         xsm_pkg::OP_CLEAR: begin
            row_in  = '0;
            rowv_in = 1'b0;
            vld_in  = 1'b0;
         end
         default: begin
            vld_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      row_ff <= row_in;
      vec_ff <= vec_in;
      if (reset) begin
         rowv_ff <= 1'b0;
         vld_ff  <= 1'b0;
      end else begin
         rowv_ff <= rowv_in;
         vld_ff  <= vld_in;
      end
   end

   assign vec_o  = vec_ff;
   assign vld_o  = vld_ff;
   assign row_o  = row_ff;
   assign rowv_o = rowv_ff;

endmodule

>>> dv/xor_split_max_sum_top_tb.sv
// Testbench for xor_split_max_sum_top: streams value sets and checks each 2*M+T result.
// Depends on xor_split_max_sum_top; predictor is self-contained.
`timescale 1ns / 1ps

module xor_split_max_sum_top_tb;

   localparam int VB = 60;
   localparam int SET_LATENCY = 4 * VB + 8;
   localparam longint CYCLE_LIMIT = 2000000;

   typedef struct {
      logic [VB-1:0] value;
      logic          last;
      logic          known;
      logic [VB:0]   sum;
   } stim_row_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   logic [VB-1:0]     req_value = '0;
   logic              req_last = 1'b0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   logic [VB:0]       rsp_max_sum;

   logic [VB-1:0]     set_xor;
   logic [VB-1:0]     span_rows [VB];
   logic              span_used [VB];
   logic [VB:0]       sums_due [$];
   int                mismatch_count = 0;
   longint            cycle_count = 0;
   int                send_idle_pct = 0;
   int                recv_idle_pct = 0;
   bit                hold_rsp = 1'b0;
   stim_row_type      stim_rows [$];

   xor_split_max_sum_top #(.VALUE_BITS(VB)) u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_value(req_value), .req_last(req_last),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_max_sum(rsp_max_sum)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   task automatic report_mismatch(input string what);
      $display("%0t: %s", $realtime, what);
      mismatch_count++;
   endtask

   function automatic void span_insert(ref logic [VB-1:0] rows [VB], ref logic used [VB],
                                       input logic [VB-1:0] v);
      for (int b = VB - 1; b >= 0; b--) begin
         if (v[b]) begin
            if (!used[b]) begin
               rows[b] = v;
               used[b] = 1'b1;
               return;
            end
            v ^= rows[b];
         end
      end
   endfunction

   function automatic void clear_set();
      set_xor = '0;
      for (int b = 0; b < VB; b++) begin
         span_rows[b] = '0;
         span_used[b] = 1'b0;
      end
   endfunction

   // absorbs one value; returns 1 with the split sum when the set closes
   function automatic bit predict_split_sum(input logic [VB-1:0] v, input logic last,
                                            output logic [VB:0] sum);
      logic [VB-1:0] keep, best;
      logic [VB-1:0] red [VB];
      logic          rused [VB];
      sum = '0;
      set_xor ^= v;
      span_insert(span_rows, span_used, v);
      if (!last) return 0;
      keep = ~set_xor;
      for (int b = 0; b < VB; b++) begin
         red[b] = '0;
         rused[b] = 1'b0;
      end
      for (int b = 0; b < VB; b++)
         if (span_used[b]) span_insert(red, rused, span_rows[b] & keep);
      best = '0;
      for (int b = VB - 1; b >= 0; b--)
         if (rused[b] && ((best ^ red[b]) > best)) best ^= red[b];
      sum = {best, 1'b0} + {1'b0, set_xor};
      clear_set();
      return 1;
   endfunction

   task automatic send_value(input logic [VB-1:0] v, input logic last,
                             input logic known, input logic [VB:0] typed_sum);
      logic [VB:0] sum;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_value <= v;
      req_last  <= last;
      do @(posedge clock); while (!req_ready);
      if (predict_split_sum(v, last, sum)) begin
         if (known && sum !== typed_sum)
            report_mismatch($sformatf("typed sum %h vs predictor %h", typed_sum, sum));
         sums_due = {sums_due, sum};
      end
      @(negedge clock);
   endtask

   task automatic wait_drained();
      int guard;
      guard = 0;
      req_valid <= 1'b0;
      while (sums_due.size() != 0 && guard < 100000) begin
         @(negedge clock);
         guard++;
      end
      repeat (SET_LATENCY) @(negedge clock);
   endtask

   function automatic logic [VB-1:0] rand_value();
      logic [VB-1:0] v;
      v = VB'({$urandom, $urandom});
      case ($urandom_range(5))
         0: v = VB'(1) << $urandom_range(VB - 1);
         1: v = v >> $urandom_range(VB - 1);
         2: v = v & {{(VB-8){1'b0}}, 8'hff};
         default: ;
      endcase
      return v;
   endfunction

   task automatic random_sets(input int n_items);
      int sent, len;
      sent = 0;
      while (sent < n_items) begin
         len = ($urandom_range(9) == 0) ? $urandom_range(80, 200) : $urandom_range(1, 12);
         if (len > n_items - sent) len = n_items - sent;
         for (int i = 0; i < len; i++) begin
            send_value(rand_value(), i == len - 1, 1'b0, '0);
            sent++;
         end
      end
   endtask

   // result side
   always @(negedge clock) begin
      if (reset || hold_rsp) rsp_ready <= 1'b0;
      else rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (sums_due.size() == 0)
            report_mismatch($sformatf("unexpected transfer max_sum=%h", rsp_max_sum));
         else begin
            if (rsp_max_sum !== sums_due[0])
               report_mismatch($sformatf("max_sum %h expected %h", rsp_max_sum, sums_due[0]));
            void'(sums_due.pop_front());
         end
      end
   end

   localparam logic [VB-1:0] ALL1 = {VB{1'b1}};

   initial begin
      clear_set();
      // directed rows: value, last, typed?, typed sum
      stim_rows = '{
         '{'0, 1'b1, 1'b1, '0},
         '{ALL1, 1'b1, 1'b1, {1'b0, ALL1}},
         '{ALL1, 1'b0, 1'b0, '0}, '{ALL1, 1'b1, 1'b1, {ALL1, 1'b0}},
         '{60'h5, 1'b0, 1'b0, '0}, '{60'h3, 1'b1, 1'b0, '0},
         '{60'h1, 1'b0, 1'b0, '0}, '{60'h1, 1'b0, 1'b0, '0}, '{60'h1, 1'b1, 1'b0, '0},
         '{60'h800000000000000, 1'b0, 1'b0, '0}, '{60'h1, 1'b1, 1'b0, '0},
         '{60'hAAAAAAAAAAAAAAA, 1'b0, 1'b0, '0}, '{60'h555555555555555, 1'b0, 1'b0, '0},
         '{60'hFFFFFFFFFFFFFFF, 1'b1, 1'b0, '0},
         '{60'h123456789ABCDEF, 1'b0, 1'b0, '0},
         '{60'h123456789ABCDEF, 1'b1, 1'b1, {60'h123456789ABCDEF, 1'b0}},
         '{60'h00F, 1'b0, 1'b0, '0}, '{60'h0F0, 1'b0, 1'b0, '0}, '{60'h0FF, 1'b1, 1'b0, '0}
      };
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      foreach (stim_rows[i])
         send_value(stim_rows[i].value, stim_rows[i].last, stim_rows[i].known,
                    stim_rows[i].sum);
      wait_drained();

      send_idle_pct = 16; recv_idle_pct = 75;
      random_sets(450);
      // receiver holds off while the sender keeps offering
      fork
         begin
            hold_rsp = 1'b1;
            repeat (800) @(negedge clock);
            hold_rsp = 1'b0;
         end
         random_sets(40);
      join
      wait_drained();
      send_idle_pct = 75; recv_idle_pct = 16;
      random_sets(450);
      send_idle_pct = 0; recv_idle_pct = 0;
      random_sets(450);
      wait_drained();

      if (mismatch_count == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule

>>> filelist.f
+incdir+hw/rtl
hw/rtl/xsm_pkg.sv
hw/rtl/xsm_cell.sv
hw/rtl/xor_split_max_sum_top.sv
dv/xor_split_max_sum_top_tb.sv
